[rtl/core/assert_macros.svh]
// Assertion macros shared by the arithmetic unit RTL.
// Each macro expects a clock named i_clk and an active-low reset i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/core/gf2n_pkg.sv]
// ----------------------------------------------------------------------------
// gf2n_pkg
// Shared types, codes and field arithmetic for the GF(2^n) arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gf2n_pkg;

    typedef enum logic [1:0] {
        CMD_MUL = 2'd0,
        CMD_INV = 2'd1,
        CMD_POW = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        FIELD_8  = 2'd0,
        FIELD_16 = 2'd1,
        FIELD_32 = 2'd2
    } t_field;

    // Low-order terms of the reduction polynomials (leading x^n dropped)
    localparam logic [12:0] POLY8  = 13'h001B;
    localparam logic [12:0] POLY16 = 13'h100B;
    localparam logic [12:0] POLY32 = 13'h008D;

    typedef struct packed {
        logic load;
        logic mul_step;
        logic sqr_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic exp_init_zero;
        logic exp_last;
    } t_dp_status;

    function automatic logic [31:0] field_mask(logic [1:0] f);
        logic [31:0] m;
        case (f)
            FIELD_8:  m = 32'h0000_00FF;
            FIELD_16: m = 32'h0000_FFFF;
            FIELD_32: m = 32'hFFFF_FFFF;
            default:  m = 32'h0000_0000;
        endcase
        return m;
    endfunction

    function automatic logic [63:0] clmul32(logic [31:0] a, logic [31:0] b);
        logic [63:0] acc;
        acc = '0;
        for (int i = 0; i < 32; i++) begin
            if (b[i]) begin
                acc = acc ^ ({32'b0, a} << i);
            end
        end
        return acc;
    endfunction

    function automatic logic [44:0] clmul_poly(logic [31:0] x, logic [12:0] y);
        logic [44:0] acc;
        acc = '0;
        for (int i = 0; i < 13; i++) begin
            if (y[i]) begin
                acc = acc ^ ({13'b0, x} << i);
            end
        end
        return acc;
    endfunction

    // Field multiply of two masked elements: carry-less product, then fold
    // the high half back through the polynomial until it vanishes.
    function automatic logic [31:0] fmul(logic [31:0] a, logic [31:0] b, logic [1:0] f);
        logic [63:0] p;
        logic [31:0] r;
        p = clmul32(a, b);
        r = '0;
        case (f)
            FIELD_8: begin
                for (int i = 0; i < 2; i++) begin
                    p = (p & 64'h0000_0000_0000_00FF) ^ {19'b0, clmul_poly(p[39:8], POLY8)};
                end
                r = p[31:0];
            end
            FIELD_16: begin
                for (int i = 0; i < 4; i++) begin
                    p = (p & 64'h0000_0000_0000_FFFF) ^ {19'b0, clmul_poly(p[47:16], POLY16)};
                end
                r = p[31:0];
            end
            FIELD_32: begin
                for (int i = 0; i < 2; i++) begin
                    p = (p & 64'h0000_0000_FFFF_FFFF) ^ {19'b0, clmul_poly(p[63:32], POLY32)};
                end
                r = p[31:0];
            end
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/core/gf2n_if.sv]
// ----------------------------------------------------------------------------
// gf2n_in_if / gf2n_out_if
// Valid/ready channels carrying operation words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface gf2n_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [31:0] operand_a;
    logic [31:0] operand_b;

    modport source (output valid, output cmd, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input cmd, input operand_a, input operand_b,
                    output ready);
endinterface

interface gf2n_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] result;

    modport source (output valid, output result, input ready);
    modport sink   (input valid, input result, output ready);
endinterface

`default_nettype wire

[rtl/core/gf2n_arith_unit_core.sv]
// ----------------------------------------------------------------------------
// gf2n_arith_unit_core
// Multiply, inverse and power over GF(2^8), GF(2^16) or GF(2^32).
// ----------------------------------------------------------------------------
// One word is worked on at a time. A single field multiplier, one full
// multiply per cycle, is shared between the multiply and squaring steps of
// square-and-multiply, so the exponent length L (index of its top set bit
// plus one) sets the time: after acceptance the unit makes L multiply steps
// with a squaring step between each two, then loads the result; multiply
// runs as a one-bit exponent. A zero exponent, an unused command or an
// unused field code skips the steps. The finished result
// sits in an output register, so the next word is accepted while it waits.
// field_size may only be written while the unit is idle.
`default_nettype none

`include "assert_macros.svh"

module gf2n_arith_unit_core (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_wr_en,
    input  wire logic [1:0] i_cfg_wr_data,
    gf2n_in_if.sink         i_in,
    gf2n_out_if.source      o_out
);

    logic [1:0]           r_field;
    gf2n_pkg::t_dp_cmd    dp_cmd;
    gf2n_pkg::t_dp_status dp_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field <= gf2n_pkg::FIELD_8;
        end else if (i_cfg_wr_en) begin
            r_field <= i_cfg_wr_data;
        end
    end

    gf2n_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    gf2n_dp u_dp (
        .i_clk       (i_clk),
        .i_cmd       (dp_cmd),
        .i_field     (r_field),
        .i_op        (i_in.cmd),
        .i_operand_a (i_in.operand_a),
        .i_operand_b (i_in.operand_b),
        .o_status    (dp_status),
        .o_result    (o_out.result)
    );

    `ASSERT_CLK(a_busy_after_accept, i_in.valid && i_in.ready |=> !i_in.ready,
        "word accepted while previous one still in flight")
    `ASSERT_CLK(a_gf8_upper_zero,
        o_out.valid && r_field == gf2n_pkg::FIELD_8 |-> o_out.result[31:8] == 24'd0,
        "GF(2^8) result has bits above field width")
    `ASSERT_CLK(a_gf16_upper_zero,
        o_out.valid && r_field == gf2n_pkg::FIELD_16 |-> o_out.result[31:16] == 16'd0,
        "GF(2^16) result has bits above field width")

endmodule

`default_nettype wire

[rtl/core/gf2n_ctrl.sv]
// ----------------------------------------------------------------------------
// gf2n_ctrl
// Sequencer for square-and-multiply: steps the shared multiplier and owns
// the input and output handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module gf2n_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    input  wire gf2n_pkg::t_dp_status  i_status,
    output gf2n_pkg::t_dp_cmd          o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_SQR,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready, n_in_ready;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd.load     = i_in_valid && r_in_ready;
        o_cmd.mul_step = (r_state == S_MUL);
        o_cmd.sqr_step = (r_state == S_SQR);
        o_cmd.out_load = (r_state == S_DONE) && out_free;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.load) begin
                    n_state = i_status.exp_init_zero ? S_DONE : S_MUL;
                end
            end
            S_MUL: n_state = i_status.exp_last ? S_DONE : S_SQR;
            S_SQR: n_state = S_MUL;
            S_DONE: begin
                // hold until the output register can take the word
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_in_ready = (n_state == S_IDLE);
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_ready  <= n_in_ready;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

    `ASSERT_CLK(a_ready_only_idle, r_in_ready |-> r_state == S_IDLE,
        "input ready outside idle")
    `ASSERT_CLK(a_sqr_follows_mul, r_state == S_SQR |-> $past(r_state) == S_MUL,
        "squaring step not preceded by a multiply step")
    `ASSERT_CLK(a_zero_exp_done, o_cmd.load && i_status.exp_init_zero |=> r_state == S_DONE,
        "zero exponent did not finish at once")

endmodule

`default_nettype wire

[rtl/core/gf2n_dp.sv]
// ----------------------------------------------------------------------------
// gf2n_dp
// Accumulator, base and exponent registers around one shared field
// multiplier, plus the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gf2n_dp (
    input  wire logic                 i_clk,
    input  wire gf2n_pkg::t_dp_cmd    i_cmd,
    input  wire logic [1:0]           i_field,
    input  wire logic [1:0]           i_op,
    input  wire logic [31:0]          i_operand_a,
    input  wire logic [31:0]          i_operand_b,
    output gf2n_pkg::t_dp_status      o_status,
    output logic [31:0]               o_result
);

    logic [31:0] r_acc, n_acc;
    logic [31:0] r_base, n_base;
    logic [31:0] r_exp, n_exp;
    logic [31:0] r_result;
    logic [31:0] mask;
    logic [31:0] mul_x;
    logic [31:0] prod;
    logic [31:0] init_acc, init_base, init_exp;
    logic        field_ok;

    assign mask     = gf2n_pkg::field_mask(i_field);
    assign field_ok = (i_field == gf2n_pkg::FIELD_8) || (i_field == gf2n_pkg::FIELD_16)
                   || (i_field == gf2n_pkg::FIELD_32);

    // Multiply runs as a one-bit exponent with the first factor preloaded.
    always_comb begin
        init_acc  = 32'd1;
        init_base = i_operand_a & mask;
        init_exp  = '0;
        case (i_op)
            gf2n_pkg::CMD_MUL: begin
                init_acc  = i_operand_a & mask;
                init_base = i_operand_b & mask;
                init_exp  = 32'd1;
            end
            gf2n_pkg::CMD_INV: init_exp = mask - 32'd1;
            gf2n_pkg::CMD_POW: init_exp = i_operand_b;
            default: begin
                init_acc = '0;
                init_exp = '0;
            end
        endcase
        if (!field_ok) begin
            init_acc = '0;
            init_exp = '0;
        end
    end

    assign mul_x = i_cmd.sqr_step ? r_base : r_acc;
    assign prod  = gf2n_pkg::fmul(mul_x, r_base, i_field);

    always_comb begin
        n_acc  = r_acc;
        n_base = r_base;
        n_exp  = r_exp;
        if (i_cmd.load) begin
            n_acc  = init_acc;
            n_base = init_base;
            n_exp  = init_exp;
        end else if (i_cmd.mul_step) begin
            if (r_exp[0]) begin
                n_acc = prod;
            end
            n_exp = {1'b0, r_exp[31:1]};
        end else if (i_cmd.sqr_step) begin
            n_base = prod;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_base <= n_base;
        r_exp  <= n_exp;
        if (i_cmd.out_load) begin
            r_result <= r_acc;
        end
    end

    assign o_status.exp_init_zero = (init_exp == '0);
    assign o_status.exp_last      = (r_exp[31:1] == '0);
    assign o_result               = r_result;

endmodule

`default_nettype wire
